// ===== design/complete_tree_array_store_core_defines.svh =====
// Assertion macros for complete_tree_array_store_core.
`ifndef COMPLETE_TREE_ARRAY_STORE_CORE_DEFINES_SVH
`define COMPLETE_TREE_ARRAY_STORE_CORE_DEFINES_SVH
`ifndef SYNTH
// Expression must hold at every clock edge out of reset.
`define CTAS_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ctas: check failed");
// Implication check: cons must follow ante as written.
`define CTAS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("ctas: check failed");
`else
`define CTAS_ASSERT(lbl, expr)
`define CTAS_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== design/ctas_pkg.sv =====
// Shared constants, codes, types and functions for the tree store.
package ctas_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DATA_W       = 32;
	localparam int CNT_W        = 7;   // holds counts up to the largest capacity
	localparam int CMD_W        = 3;
	localparam int STAT_W       = 2;
	localparam int HGT_W        = 3;
	localparam int OCNT_W       = 6;

	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PRE    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_IN     = 3'd5;
	localparam logic [CMD_W-1:0] CMD_POST   = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic              en;
		logic [DATA_W-1:0] data;
	} ctas_wr_t;

	// levels of a complete tree holding n items: index of top set bit plus one
	function automatic logic [HGT_W-1:0] tree_levels(input logic [CNT_W-1:0] n);
		logic [HGT_W-1:0] h;
		h = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (n[i]) begin
				h = HGT_W'(i + 1);
			end
		end
		return h;
	endfunction

endpackage

// ===== design/ctas_slot_ram.sv =====
// Slot memory: one write port, one registered read port.
module ctas_slot_ram #(
	parameter int DEPTH = ctas_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(ctas_pkg::CAPACITY_DEF)
) (
	input  logic                         clk,
	input  ctas_pkg::ctas_wr_t           wr,
	input  logic [AW-1:0]                wr_addr,
	input  logic [AW-1:0]                rd_addr,
	output logic [ctas_pkg::DATA_W-1:0]  rd_data
);
	import ctas_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/complete_tree_array_store_core.sv =====
// Top level of the array-backed complete binary tree store.
//
// Usage: one request word enters on in_valid/in_ready with command and
// item_value. Result words leave on out_valid/out_ready, each with
// out_value, status, item_count, tree_height and last. Add, remove,
// contains, clear and unknown commands give one word; preorder, inorder
// and postorder give one word per stored item (one word with status
// tree-empty when the tree is empty), last marking the final one.
// The search reads one slot per cycle through the single memory read
// port; remove then reads the last slot and writes it into the hit slot.
// A walk reads one slot per item, and moving to the next slot steps the
// index sequencer one level a cycle.
// One request is worked on at a time; in_ready is high only while idle.
// Reset clears the item count and all control state; the slot memory is
// not cleared (unfilled slots are never used). When the receiver stalls,
// the result register holds its word and the walk waits for it to drain.
`include "complete_tree_array_store_core_defines.svh"
module complete_tree_array_store_core #(
	parameter int CAPACITY = ctas_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ctas_pkg::CMD_W-1:0]          command,
	input  logic signed [ctas_pkg::DATA_W-1:0]  item_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ctas_pkg::DATA_W-1:0]  out_value,
	output logic [ctas_pkg::STAT_W-1:0]         status,
	output logic [ctas_pkg::OCNT_W-1:0]         item_count,
	output logic [ctas_pkg::HGT_W-1:0]          tree_height,
	output logic                                last
);
	import ctas_pkg::*;

	localparam int AW  = $clog2(CAPACITY);
	localparam int IW  = $clog2(CAPACITY + 1);
	localparam int CHW = IW + 1;
	localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EXEC    = 4'd1;
	localparam logic [3:0] S_SRCH    = 4'd2;
	localparam logic [3:0] S_RDLAST  = 4'd3;
	localparam logic [3:0] S_MOVE    = 4'd4;
	localparam logic [3:0] S_RESP    = 4'd5;
	localparam logic [3:0] S_DESC    = 4'd6;
	localparam logic [3:0] S_EMIT_RD = 4'd7;
	localparam logic [3:0] S_EMIT_LD = 4'd8;
	localparam logic [3:0] S_NXT     = 4'd9;
	localparam logic [3:0] S_CLIMB   = 4'd10;

	logic [3:0]        state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [IW-1:0]     occ_q;
	logic [STAT_W-1:0] res_st_q;

	// search
	logic [IW-1:0] idx_q;
	logic          pend_q;
	logic [AW-1:0] pidx_q;
	logic [AW-1:0] hit_idx_q;

	// walk
	logic [IW-1:0] cur_q;
	logic [IW-1:0] emit_q;

	// result register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [STAT_W-1:0] out_st_q;
	logic [OCNT_W-1:0] out_cnt_q;
	logic [HGT_W-1:0]  out_hgt_q;
	logic              out_last_q;

	ctas_wr_t          wr;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	logic [CHW-1:0] occ_x, child_l, child_r, sib;
	logic [IW-1:0]  occ_m1, cur_m1;
	logic [CNT_W-1:0] occ_c;
	logic           out_free, hit, walk_st, is_last;
	logic           add_acc;

	ctas_slot_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// index arithmetic of the walk unit
	assign occ_x   = {1'b0, occ_q};
	assign child_l = {cur_q, 1'b0};
	assign child_r = {cur_q, 1'b1};
	assign sib     = {1'b0, cur_q} + CHW'(1);
	assign occ_m1  = occ_q - IW'(1);
	assign cur_m1  = cur_q - IW'(1);
	assign occ_c   = CNT_W'(occ_q);

	assign out_free = !out_valid_q || out_ready;
	assign hit      = pend_q && (rd_data == val_q);
	assign is_last  = (emit_q + IW'(1)) == occ_q;
	assign walk_st  = (state_q == S_DESC) || (state_q == S_EMIT_RD) ||
	                  (state_q == S_EMIT_LD) || (state_q == S_NXT) ||
	                  (state_q == S_CLIMB);
	assign add_acc  = in_valid && in_ready && (command == CMD_ADD) && (occ_q != CAP_I);

	always_comb begin
		unique case (state_q)
			S_SRCH:   rd_addr = idx_q[AW-1:0];
			S_RDLAST: rd_addr = occ_m1[AW-1:0];
			default:  rd_addr = cur_m1[AW-1:0];
		endcase
	end

	always_comb begin
		wr.en   = 1'b0;
		wr.data = val_q;
		wr_addr = occ_q[AW-1:0];
		if (state_q == S_EXEC && cmd_q == CMD_ADD && occ_q != CAP_I) begin
			wr.en = 1'b1;
		end else if (state_q == S_MOVE) begin
			wr.en   = 1'b1;
			wr.data = rd_data;
			wr_addr = hit_idx_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			occ_q    <= '0;
			pend_q   <= 1'b0;
			cmd_q    <= CMD_ADD;
			res_st_q <= ST_OK;
			idx_q    <= '0;
			cur_q    <= '0;
			emit_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q) inside
						CMD_ADD: begin
							if (occ_q == CAP_I) begin
								res_st_q <= ST_FULL;
							end else begin
								res_st_q <= ST_OK;
								occ_q    <= occ_q + IW'(1);
							end
							state_q <= S_RESP;
						end
						CMD_REMOVE, CMD_FIND: begin
							if (occ_q == '0) begin
								res_st_q <= ST_EMPTY;
								state_q  <= S_RESP;
							end else begin
								idx_q   <= '0;
								pend_q  <= 1'b0;
								state_q <= S_SRCH;
							end
						end
						CMD_CLEAR: begin
							occ_q    <= '0;
							res_st_q <= ST_OK;
							state_q  <= S_RESP;
						end
						CMD_PRE, CMD_IN, CMD_POST: begin
							if (occ_q == '0) begin
								res_st_q <= ST_EMPTY;
								state_q  <= S_RESP;
							end else begin
								cur_q   <= IW'(1);
								emit_q  <= '0;
								state_q <= (cmd_q == CMD_PRE) ? S_EMIT_RD : S_DESC;
							end
						end
						default: begin
							res_st_q <= ST_OK;
							state_q  <= S_RESP;
						end
					endcase
				end
				S_SRCH: begin
					// one slot read issued per cycle, compared the next
					if (hit) begin
						pend_q   <= 1'b0;
						res_st_q <= ST_OK;
						state_q  <= (cmd_q == CMD_REMOVE) ? S_RDLAST : S_RESP;
					end else if (idx_q < occ_q) begin
						pend_q <= 1'b1;
						idx_q  <= idx_q + IW'(1);
					end else begin
						pend_q   <= 1'b0;
						res_st_q <= ST_MISS;
						state_q  <= S_RESP;
					end
				end
				S_RDLAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					occ_q   <= occ_m1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DESC: begin
					// run down left children to the leftmost node below cur
					if (child_l <= occ_x) begin
						cur_q <= child_l[IW-1:0];
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					if (out_free) begin
						emit_q  <= emit_q + IW'(1);
						state_q <= is_last ? S_IDLE : S_NXT;
					end
				end
				S_NXT: begin
					unique case (cmd_q)
						CMD_PRE: begin
							if (child_l <= occ_x) begin
								cur_q   <= child_l[IW-1:0];
								state_q <= S_EMIT_RD;
							end else begin
								state_q <= S_CLIMB;
							end
						end
						CMD_IN: begin
							if (child_r <= occ_x) begin
								cur_q   <= child_r[IW-1:0];
								state_q <= S_DESC;
							end else begin
								state_q <= S_CLIMB;
							end
						end
						default: begin
							// postorder: right sibling subtree next, else parent
							if (!cur_q[0] && sib <= occ_x) begin
								cur_q   <= sib[IW-1:0];
								state_q <= S_DESC;
							end else begin
								cur_q   <= cur_q >> 1;
								state_q <= S_EMIT_RD;
							end
						end
					endcase
				end
				S_CLIMB: begin
					unique case (cmd_q)
						CMD_PRE: begin
							if (cur_q[0] || sib > occ_x) begin
								cur_q <= cur_q >> 1;
							end else begin
								cur_q   <= sib[IW-1:0];
								state_q <= S_EMIT_RD;
							end
						end
						default: begin
							// inorder: climb out of right children, emit parent
							cur_q <= cur_q >> 1;
							if (!cur_q[0]) begin
								state_q <= S_EMIT_RD;
							end
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			val_q <= item_value;
		end
		if (state_q == S_SRCH) begin
			if (!hit) begin
				pidx_q <= idx_q[AW-1:0];
			end else begin
				hit_idx_q <= pidx_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESP || state_q == S_EMIT_LD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESP || state_q == S_EMIT_LD) && out_free) begin
			out_cnt_q <= occ_c[OCNT_W-1:0];
			out_hgt_q <= tree_levels(occ_c);
			if (state_q == S_RESP) begin
				out_value_q <= '0;
				out_st_q    <= res_st_q;
				out_last_q  <= 1'b1;
			end else begin
				out_value_q <= rd_data;
				out_st_q    <= ST_OK;
				out_last_q  <= is_last;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign status      = out_st_q;
	assign item_count  = out_cnt_q;
	assign tree_height = out_hgt_q;
	assign last        = out_last_q;

	`CTAS_ASSERT(a_occ_bound, occ_q <= CAP_I)
	`CTAS_ASSERT_IMPL(a_walk_emit, walk_st, emit_q < occ_q)
	`CTAS_ASSERT_IMPL(a_more_words, out_valid && !last, walk_st)
	`CTAS_ASSERT_IMPL(a_add_grows, add_acc, ##2 (occ_q == $past(occ_q, 2) + IW'(1)))

endmodule
